/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files of the accent weight core.
// No dependencies; the files that assert include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in every cycle in which ante holds
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// cond must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`endif

/* hw/rtl/bgaw_pkg.sv */
// Types and constants of the beat grid accent weight core.
// No dependencies; every RTL module refers to it by scoped names.
package bgaw_pkg;

    localparam int BEATS_W  = 6;
    localparam int TOL_W    = 14;
    localparam int BOOST_W  = 16;
    localparam int RED_W    = 16;
    localparam int MAG_W    = 17;
    localparam int IDX_W    = 8;
    localparam int CLASS_W  = 3;
    localparam int WEIGHT_W = 19;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 4;

    // compare-subtract steps held between two pipeline registers
    localparam int STEPS_PER_STAGE = 4;

    // floor(boost * 11 / 20) = (boost * STRONG_MUL) >> STRONG_SHIFT
    localparam int STRONG_MUL_W = 24;
    localparam logic [STRONG_MUL_W-1:0] STRONG_MUL = 24'd9227471;
    localparam int STRONG_SHIFT = 24;
    // floor(red * 2 / 5) = (red * QUARTER_MUL) >> QUARTER_SHIFT
    localparam int QUARTER_MUL_W = 19;
    localparam logic [QUARTER_MUL_W-1:0] QUARTER_MUL = 19'd419432;
    localparam int QUARTER_SHIFT = 20;

    localparam logic [IDX_W-1:0]   STRONG_IDX       = 8'd8;
    localparam logic [BEATS_W-1:0] STRONG_MIN_BEATS = 6'd4;

    localparam logic [BEATS_W-1:0] BEATS_RST = 6'd4;
    localparam logic [TOL_W-1:0]   TOL_RST   = 14'd1638;
    localparam logic [BOOST_W-1:0] BOOST_RST = 16'd13107;
    localparam logic [RED_W-1:0]   RED_RST   = 16'd6554;

    typedef enum logic [1:0] {
        REG_BEATS = 2'd0,
        REG_TOL   = 2'd1,
        REG_BOOST = 2'd2,
        REG_RED   = 2'd3
    } reg_idx_t;

    typedef enum logic [CLASS_W-1:0] {
        CLS_DOWNBEAT  = 3'd0,
        CLS_STRONG    = 3'd1,
        CLS_QUARTER   = 3'd2,
        CLS_EIGHTH    = 3'd3,
        CLS_SIXTEENTH = 3'd4
    } beat_class_t;

    typedef struct packed {
        logic [BEATS_W-1:0] beats;
        logic [TOL_W-1:0]   tol;
        logic [BOOST_W-1:0] boost;
        logic [RED_W-1:0]   red;
    } cfg_t;

    // per-word accent terms carried alongside the ratio divider
    typedef struct packed {
        beat_class_t        cls;
        logic               off_grid;
        logic               force_zero;
        logic               neg;
        logic [MAG_W-1:0]   mag;
    } acc_t;

endpackage

/* hw/rtl/bgaw_cfg.sv */
// APB register file of the accent weight core.
// Depends on bgaw_pkg.
module bgaw_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bgaw_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bgaw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bgaw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output bgaw_pkg::cfg_t                     cfg
);

    logic [bgaw_pkg::BEATS_W-1:0] beats_reg;
    logic [bgaw_pkg::TOL_W-1:0]   tol_reg;
    logic [bgaw_pkg::BOOST_W-1:0] boost_reg;
    logic [bgaw_pkg::RED_W-1:0]   red_reg;
    bgaw_pkg::reg_idx_t           reg_idx;
    logic                         wr_en;

    assign reg_idx = bgaw_pkg::reg_idx_t'(paddr[bgaw_pkg::APB_ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beats_reg <= bgaw_pkg::BEATS_RST;
            tol_reg   <= bgaw_pkg::TOL_RST;
            boost_reg <= bgaw_pkg::BOOST_RST;
            red_reg   <= bgaw_pkg::RED_RST;
        end else if (wr_en) begin
            case (reg_idx)
                bgaw_pkg::REG_BEATS: beats_reg <= pwdata[bgaw_pkg::BEATS_W-1:0];
                bgaw_pkg::REG_TOL:   tol_reg   <= pwdata[bgaw_pkg::TOL_W-1:0];
                bgaw_pkg::REG_BOOST: boost_reg <= pwdata[bgaw_pkg::BOOST_W-1:0];
                bgaw_pkg::REG_RED:   red_reg   <= pwdata[bgaw_pkg::RED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bgaw_pkg::REG_BEATS: prdata = bgaw_pkg::APB_DATA_W'(beats_reg);
            bgaw_pkg::REG_TOL:   prdata = bgaw_pkg::APB_DATA_W'(tol_reg);
            bgaw_pkg::REG_BOOST: prdata = bgaw_pkg::APB_DATA_W'(boost_reg);
            bgaw_pkg::REG_RED:   prdata = bgaw_pkg::APB_DATA_W'(red_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.beats = beats_reg;
    assign cfg.tol   = tol_reg;
    assign cfg.boost = boost_reg;
    assign cfg.red   = red_reg;

endmodule

/* hw/rtl/bgaw_fold.sv */
// Bar fold: pipelined remainder of the integer beat count by the bar length.
// Depends on bgaw_pkg.
module bgaw_fold #(
    parameter int FRAC_BITS = 16,
    parameter int POS_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bgaw_pkg::BEATS_W-1:0]  beats,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [POS_WIDTH-1:0]          in_pos,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bgaw_pkg::BEATS_W-1:0]  out_rem,
    output logic [FRAC_BITS-1:0]          out_frac
);

    localparam int STEPS = bgaw_pkg::STEPS_PER_STAGE;
    localparam int BW    = bgaw_pkg::BEATS_W;
    // integer bits below the sign bit, one per step, MSB first
    localparam int NB    = POS_WIDTH - FRAC_BITS - 1;
    localparam int NST   = (NB + STEPS - 1) / STEPS;

    logic [BW-1:0]        n_eff;
    logic                 v_reg    [NST];
    logic                 rdy      [NST+1];
    logic [NB-1:0]        ib_reg   [NST];
    logic [FRAC_BITS-1:0] frac_reg [NST];
    logic [BW-1:0]        rem_reg  [NST];

    assign n_eff    = (beats == '0) ? BW'(1) : beats;
    assign rdy[NST] = out_ready;

    for (genvar g = 0; g < NST; g++) begin : g_stage
        logic                 vin;
        logic [NB-1:0]        ib_in;
        logic [NB-1:0]        ib_out;
        logic [FRAC_BITS-1:0] frac_in;
        logic [BW-1:0]        rem_in;
        logic [BW-1:0]        rem_out;

        if (g == 0) begin : g_first
            // sign bit weighs -2^k: start the remainder at -1 mod n
            assign vin     = in_valid;
            assign ib_in   = in_pos[POS_WIDTH-2:FRAC_BITS];
            assign frac_in = in_pos[FRAC_BITS-1:0];
            assign rem_in  = in_pos[POS_WIDTH-1] ? n_eff - BW'(1) : '0;
        end else begin : g_later
            assign vin     = v_reg[g-1];
            assign ib_in   = ib_reg[g-1];
            assign frac_in = frac_reg[g-1];
            assign rem_in  = rem_reg[g-1];
        end

        always_comb begin
            logic [BW:0]   t;
            logic [NB-1:0] ib_w;
            t       = '0;
            ib_w    = ib_in;
            rem_out = rem_in;
            for (int j = 0; j < STEPS; j++) begin
                if (g * STEPS + j < NB) begin
                    t = {rem_out, ib_w[NB-1]};
                    if (t >= {1'b0, n_eff}) begin
                        t = t - {1'b0, n_eff};
                    end
                    rem_out = t[BW-1:0];
                    ib_w    = ib_w << 1;
                end
            end
            ib_out = ib_w;
        end

        assign rdy[g] = !v_reg[g] || rdy[g+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (rdy[g]) begin
                v_reg[g] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[g] && vin) begin
                ib_reg[g]   <= ib_out;
                frac_reg[g] <= frac_in;
                rem_reg[g]  <= rem_out;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];
    assign out_rem   = rem_reg[NST-1];
    assign out_frac  = frac_reg[NST-1];

endmodule

/* hw/rtl/bgaw_snap.sv */
// Snap stage: sixteenth-grid index, snap error, class and accent offset.
// Depends on bgaw_pkg.
module bgaw_snap #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bgaw_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bgaw_pkg::BEATS_W-1:0]  in_rem,
    input  logic [FRAC_BITS-1:0]          in_frac,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bgaw_pkg::acc_t                out_acc,
    output logic [bgaw_pkg::TOL_W-1:0]    out_err
);

    localparam int EW    = FRAC_BITS - 2;
    localparam int XW    = (EW > bgaw_pkg::TOL_W ? EW : bgaw_pkg::TOL_W) + 1;
    localparam int MW    = bgaw_pkg::MAG_W;
    localparam int SPW   = bgaw_pkg::BOOST_W + bgaw_pkg::STRONG_MUL_W;
    localparam int QPW   = bgaw_pkg::RED_W + bgaw_pkg::QUARTER_MUL_W;

    logic [EW-1:0]                 lo;
    logic                          half;
    logic [EW-1:0]                 err;
    logic [XW-1:0]                 err_x;
    logic [XW-1:0]                 tol_x;
    logic [bgaw_pkg::IDX_W-1:0]    idx;
    bgaw_pkg::beat_class_t         cls;
    logic [SPW-1:0]                strong_prod;
    logic [QPW-1:0]                quarter_prod;
    logic [bgaw_pkg::RED_W+1:0]    red3;
    logic [MW-1:0]                 six_mag;
    bgaw_pkg::acc_t                acc;

    logic                          v_reg;
    bgaw_pkg::acc_t                acc_reg;
    logic [bgaw_pkg::TOL_W-1:0]    err_reg;

    assign lo    = in_frac[EW-1:0];
    assign half  = lo[EW-1];
    assign idx   = {in_rem, in_frac[FRAC_BITS-1:FRAC_BITS-2]} + bgaw_pkg::IDX_W'(half);
    assign err   = half ? (~lo + 1'b1) : lo;
    assign err_x = XW'(err);
    assign tol_x = XW'(cfg.tol);

    always_comb begin
        if (idx == '0) begin
            cls = bgaw_pkg::CLS_DOWNBEAT;
        end else if (idx == bgaw_pkg::STRONG_IDX && cfg.beats >= bgaw_pkg::STRONG_MIN_BEATS) begin
            cls = bgaw_pkg::CLS_STRONG;
        end else if (idx[1:0] == 2'b00) begin
            cls = bgaw_pkg::CLS_QUARTER;
        end else if (!idx[0]) begin
            cls = bgaw_pkg::CLS_EIGHTH;
        end else begin
            cls = bgaw_pkg::CLS_SIXTEENTH;
        end
    end

    assign strong_prod  = cfg.boost * bgaw_pkg::STRONG_MUL;
    assign quarter_prod = cfg.red * bgaw_pkg::QUARTER_MUL;
    assign red3         = {1'b0, cfg.red, 1'b0} + {2'b00, cfg.red};
    assign six_mag      = red3[bgaw_pkg::RED_W+1:1];

    always_comb begin
        acc.cls        = cls;
        acc.off_grid   = err_x > tol_x;
        acc.force_zero = err_x >= tol_x;
        acc.neg        = 1'b1;
        acc.mag        = six_mag;
        if (!acc.off_grid) begin
            case (cls)
                bgaw_pkg::CLS_DOWNBEAT: begin
                    acc.neg = 1'b0;
                    acc.mag = MW'(cfg.boost);
                end
                bgaw_pkg::CLS_STRONG: begin
                    acc.neg = 1'b0;
                    acc.mag = MW'(strong_prod[bgaw_pkg::STRONG_SHIFT +: bgaw_pkg::BOOST_W]);
                end
                bgaw_pkg::CLS_QUARTER: begin
                    acc.mag = MW'(quarter_prod >> bgaw_pkg::QUARTER_SHIFT);
                end
                bgaw_pkg::CLS_EIGHTH: begin
                    acc.mag = MW'(cfg.red);
                end
                default: begin
                    acc.mag = six_mag;
                end
            endcase
        end
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            acc_reg <= acc;
            err_reg <= err_x[bgaw_pkg::TOL_W-1:0];
        end
    end

    assign out_valid = v_reg;
    assign out_acc   = acc_reg;
    assign out_err   = err_reg;

endmodule

/* hw/rtl/bgaw_ratio.sv */
// Ratio divider: pipelined restoring division of error / tolerance,
// FRAC_BITS quotient bits. Depends on bgaw_pkg.
module bgaw_ratio #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [bgaw_pkg::TOL_W-1:0]  tol,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  bgaw_pkg::acc_t              in_acc,
    input  logic [bgaw_pkg::TOL_W-1:0]  in_err,
    output logic                        out_valid,
    input  logic                        out_ready,
    output bgaw_pkg::acc_t              out_acc,
    output logic [FRAC_BITS-1:0]        out_q
);

    localparam int STEPS = bgaw_pkg::STEPS_PER_STAGE;
    localparam int TW    = bgaw_pkg::TOL_W;
    localparam int NDS   = (FRAC_BITS + STEPS - 1) / STEPS;

    logic                 v_reg   [NDS];
    logic                 rdy     [NDS+1];
    logic [TW-1:0]        r_reg   [NDS];
    logic [FRAC_BITS-1:0] q_reg   [NDS];
    bgaw_pkg::acc_t       acc_reg [NDS];

    assign rdy[NDS] = out_ready;

    for (genvar g = 0; g < NDS; g++) begin : g_stage
        logic                 vin;
        logic [TW-1:0]        r_in;
        logic [TW-1:0]        r_out;
        logic [FRAC_BITS-1:0] q_in;
        logic [FRAC_BITS-1:0] q_out;
        bgaw_pkg::acc_t       acc_in;

        if (g == 0) begin : g_first
            assign vin    = in_valid;
            assign r_in   = in_err;
            assign q_in   = '0;
            assign acc_in = in_acc;
        end else begin : g_later
            assign vin    = v_reg[g-1];
            assign r_in   = r_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign acc_in = acc_reg[g-1];
        end

        always_comb begin
            logic [TW:0]          t;
            logic [FRAC_BITS-1:0] q_w;
            t     = '0;
            q_w   = q_in;
            r_out = r_in;
            for (int j = 0; j < STEPS; j++) begin
                if (g * STEPS + j < FRAC_BITS) begin
                    t = {r_out, 1'b0};
                    if (t >= {1'b0, tol}) begin
                        t   = t - {1'b0, tol};
                        q_w = {q_w[FRAC_BITS-2:0], 1'b1};
                    end else begin
                        q_w = {q_w[FRAC_BITS-2:0], 1'b0};
                    end
                    r_out = t[TW-1:0];
                end
            end
            q_out = q_w;
        end

        assign rdy[g] = !v_reg[g] || rdy[g+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (rdy[g]) begin
                v_reg[g] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[g] && vin) begin
                r_reg[g]   <= r_out;
                q_reg[g]   <= q_out;
                acc_reg[g] <= acc_in;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NDS-1];
    assign out_acc   = acc_reg[NDS-1];
    assign out_q     = q_reg[NDS-1];

endmodule

/* hw/rtl/bgaw_weight.sv */
// Weight stages: scale the offset by the snap factor, then add, saturate
// and hold the result word. Depends on bgaw_pkg.
module bgaw_weight #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bgaw_pkg::acc_t                 in_acc,
    input  logic [FRAC_BITS-1:0]           in_q,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bgaw_pkg::WEIGHT_W-1:0]  out_weight,
    output bgaw_pkg::beat_class_t          out_cls,
    output logic                           out_off_grid
);

    localparam int MW = bgaw_pkg::MAG_W;
    localparam int FW = FRAC_BITS + 1;
    localparam int PW = MW + FW;
    localparam int WW = (FRAC_BITS > MW ? FRAC_BITS : MW) + 3;
    localparam logic [FW-1:0]        F_ONE = FW'(1) << FRAC_BITS;
    localparam logic signed [WW-1:0] W_ONE = WW'(1) << FRAC_BITS;
    localparam logic signed [WW-1:0] W_MAX = WW'(2) << FRAC_BITS;
    localparam logic signed [WW-1:0] W_MIN = -(WW'(3) << (FRAC_BITS - 1));

    logic [FW-1:0]         f;
    logic [PW-1:0]         prod;
    logic                  rdy_out;

    logic                  v1_reg;
    logic [MW-1:0]         scaled_reg;
    logic                  neg_reg;
    bgaw_pkg::beat_class_t cls1_reg;
    logic                  off1_reg;

    logic signed [WW-1:0]  w;
    logic signed [WW-1:0]  w_sat;

    logic                          v2_reg;
    logic [bgaw_pkg::WEIGHT_W-1:0] weight_reg;
    bgaw_pkg::beat_class_t         cls2_reg;
    logic                          off2_reg;

    // off grid: full reduction; error at or past tolerance: no offset
    always_comb begin
        if (in_acc.off_grid) begin
            f = F_ONE;
        end else if (in_acc.force_zero) begin
            f = '0;
        end else begin
            f = F_ONE - FW'(in_q);
        end
    end

    assign prod     = in_acc.mag * f;
    assign rdy_out  = !v2_reg || out_ready;
    assign in_ready = !v1_reg || rdy_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (in_ready) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            scaled_reg <= prod[FRAC_BITS +: MW];
            neg_reg    <= in_acc.neg;
            cls1_reg   <= in_acc.cls;
            off1_reg   <= in_acc.off_grid;
        end
    end

    always_comb begin
        if (neg_reg) begin
            w = W_ONE - $signed(WW'(scaled_reg));
        end else begin
            w = W_ONE + $signed(WW'(scaled_reg));
        end
        if (w > W_MAX) begin
            w_sat = W_MAX;
        end else if (w < W_MIN) begin
            w_sat = W_MIN;
        end else begin
            w_sat = w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy_out) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_out && v1_reg) begin
            weight_reg <= w_sat[bgaw_pkg::WEIGHT_W-1:0];
            cls2_reg   <= cls1_reg;
            off2_reg   <= off1_reg;
        end
    end

    assign out_valid    = v2_reg;
    assign out_weight   = weight_reg;
    assign out_cls      = cls2_reg;
    assign out_off_grid = off2_reg;

endmodule

/* hw/rtl/beat_grid_accent_weight_core.sv */
// Top level of the beat grid accent weight core: APB registers and the
// fold, snap, ratio and weight pipeline. Depends on bgaw_pkg, bgaw_cfg,
// bgaw_fold, bgaw_snap, bgaw_ratio, bgaw_weight and assert_macros.svh.
`include "assert_macros.svh"

// One word in, one word out, and a new word is taken every clock unless
// the output stalls. The bar remainder and the error/tolerance quotient
// each resolve four bits per stage, followed by one snap stage, one
// multiply stage and the output register. A stalled output backs the
// pipeline up without losing or repeating words. The user must see that
// registers are written over APB only while no words are in flight; the
// block itself does not enforce it. POS_WIDTH must exceed FRAC_BITS + 1.
module beat_grid_accent_weight_core #(
    parameter int FRAC_BITS = 16,
    parameter int POS_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((POS_WIDTH+7)/8)*8-1:0]      s_tdata,   // note position
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bgaw_pkg::OUT_TDATA_W-1:0]    m_tdata,   // weight, zero pad
    output logic [bgaw_pkg::OUT_TUSER_W-1:0]    m_tuser,   // beat_class, off_grid
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bgaw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bgaw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bgaw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    bgaw_pkg::cfg_t                 cfg;

    logic                           fold_valid;
    logic                           fold_ready;
    logic [bgaw_pkg::BEATS_W-1:0]   fold_rem;
    logic [FRAC_BITS-1:0]           fold_frac;

    logic                           snap_valid;
    logic                           snap_ready;
    bgaw_pkg::acc_t                 snap_acc;
    logic [bgaw_pkg::TOL_W-1:0]     snap_err;

    logic                           ratio_valid;
    logic                           ratio_ready;
    bgaw_pkg::acc_t                 ratio_acc;
    logic [FRAC_BITS-1:0]           ratio_q;

    logic [bgaw_pkg::WEIGHT_W-1:0]  weight;
    bgaw_pkg::beat_class_t          beat_class;
    logic                           off_grid;

    logic                           fold_rem_ok;
    logic                           snap_off_terms;
    logic                           snap_down_neg;

    bgaw_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bgaw_fold #(
        .FRAC_BITS (FRAC_BITS),
        .POS_WIDTH (POS_WIDTH)
    ) u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beats     (cfg.beats),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pos    (s_tdata[POS_WIDTH-1:0]),
        .out_valid (fold_valid),
        .out_ready (fold_ready),
        .out_rem   (fold_rem),
        .out_frac  (fold_frac)
    );

    bgaw_snap #(
        .FRAC_BITS (FRAC_BITS)
    ) u_snap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (fold_valid),
        .in_ready  (fold_ready),
        .in_rem    (fold_rem),
        .in_frac   (fold_frac),
        .out_valid (snap_valid),
        .out_ready (snap_ready),
        .out_acc   (snap_acc),
        .out_err   (snap_err)
    );

    bgaw_ratio #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ratio (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tol       (cfg.tol),
        .in_valid  (snap_valid),
        .in_ready  (snap_ready),
        .in_acc    (snap_acc),
        .in_err    (snap_err),
        .out_valid (ratio_valid),
        .out_ready (ratio_ready),
        .out_acc   (ratio_acc),
        .out_q     (ratio_q)
    );

    bgaw_weight #(
        .FRAC_BITS (FRAC_BITS)
    ) u_weight (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (ratio_valid),
        .in_ready     (ratio_ready),
        .in_acc       (ratio_acc),
        .in_q         (ratio_q),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_weight   (weight),
        .out_cls      (beat_class),
        .out_off_grid (off_grid)
    );

    assign m_tdata = bgaw_pkg::OUT_TDATA_W'(weight);
    assign m_tuser = {off_grid, beat_class};

    assign fold_rem_ok    = (fold_rem < cfg.beats) || (fold_rem == '0);
    assign snap_off_terms = snap_acc.force_zero && snap_acc.neg;
    assign snap_down_neg  = !snap_acc.off_grid && (snap_acc.cls == bgaw_pkg::CLS_DOWNBEAT)
                            && snap_acc.neg;

    // folded beat count stays inside the bar (a zero bar length acts as one)
    `ASSERT_IMPLY(a_fold_in_bar, aclk, aresetn, fold_valid, fold_rem_ok)
    // off grid always forces the full negative reduction path
    `ASSERT_IMPLY(a_off_grid_terms, aclk, aresetn, snap_valid && snap_acc.off_grid, snap_off_terms)
    // an on-grid downbeat never carries a reduction
    `ASSERT_NEVER(a_downbeat_sign, aclk, aresetn, snap_valid && snap_down_neg)
    // input backpressure only when the output word is held
    `ASSERT_IMPLY(a_stall_source, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

endmodule
